>>> rtl/indexed_insert_delete_array_top_defines.svh
// Assertion macros for the indexed insert/delete array.
`ifndef INDEXED_INSERT_DELETE_ARRAY_TOP_DEFINES_SVH
`define INDEXED_INSERT_DELETE_ARRAY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define IIDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define IIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/iida_pkg.sv
// Shared types and constants for the indexed insert/delete array.
package iida_pkg;

    localparam int CMD_W     = 2;
    localparam int POS_W     = 7;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Broadcast to every cell: which shift to make and where it starts.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] position;
    } cell_ctrl_t;

endpackage

>>> rtl/iida_cell.sv
// One storage cell of the array: hold, shift up, shift down or load.
module iida_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  iida_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]   load_value,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    output logic [DATA_WIDTH-1:0]   data,
    output logic [DATA_WIDTH-1:0]   rd_data
);
    import iida_pkg::*;

    logic                  hit;
    logic                  above;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    assign hit   = (32'(ctrl.position) == 32'(INDEX));
    assign above = (32'(INDEX) > 32'(ctrl.position));

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (hit)
                data_next = load_value;
            else if (above)
                data_next = left_data;
        end
        else if (ctrl.del)
        begin
            if (hit || above)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // drive the entry only when it is the one addressed, so the row can be OR-ed
    assign rd_data = hit ? data_reg : '0;

endmodule

>>> rtl/indexed_insert_delete_array_top.sv
// Top level of the indexed insert/delete array: command decode, cell row, result register.
//
//  Channel | Direction | Handshake                     | tdata fields (lowest bit first)
//  --------+-----------+-------------------------------+-----------------------------------
//  s_axis  | in        | s_axis_tvalid / s_axis_tready | command[1:0] position[8:2]
//          |           |                               | value[40:9], zero pad to 48
//  m_axis  | out       | m_axis_tvalid / m_axis_tready | status[1:0] read_value[33:2]
//          |           |                               | count[40:34], zero pad to 48
//
// All cells pick hold, shift or load together in the cycle the word is accepted, and
// the result lands in the output register on that edge.
// A word is taken whenever the output register is empty or being drained, so one word
// per cycle is sustained while the sink keeps m_axis_tready high.
// Reset clears the fill count and the output valid; cell contents stay undefined until
// written. While a result waits with m_axis_tready low, hold it and accept no new word.

`include "indexed_insert_delete_array_top_defines.svh"

module indexed_insert_delete_array_top #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // command[1:0], position[8:2], value[40:9], pad[47:41]
    input  logic [iida_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[1:0], read_value[33:2], count[40:34], pad[47:41]
    output logic [iida_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import iida_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    // unpacked input word
    cmd_t                      in_command;
    logic [POS_W-1:0]          in_position;
    logic signed [VALUE_W-1:0] in_value;
    logic [DATA_WIDTH-1:0]     val_fit;
    logic                      s_fire;

    // fill count
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] len_c;

    // command outcome
    status_t               status_now;
    logic [VALUE_W-1:0]    rd_now;
    cell_ctrl_t            ctrl;

    // cell row
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_sel;

    // result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               res_status_reg;
    logic [VALUE_W-1:0]    res_rd_reg;
    logic [COUNT_W-1:0]    res_count_reg;

    assign in_command  = cmd_t'(s_axis_tdata[CMD_W-1:0]);
    assign in_position = s_axis_tdata[CMD_W +: POS_W];
    assign in_value    = s_axis_tdata[CMD_W+POS_W +: VALUE_W];
    // fit the signed value to the stored width: sign-extend or drop upper bits
    assign val_fit     = DATA_WIDTH'(in_value);

    // output register frees its slot as soon as the sink takes the word
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign pos_c = CMP_W'(in_position);
    assign len_c = CMP_W'(len_reg);

    // OR the row: only the addressed cell drives non-zero data
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_sel = rd_sel | cell_rd[i];
    end

    // decode the command against the current count
    always_comb
    begin
        status_now    = ST_DONE;
        rd_now        = '0;
        len_next      = len_reg;
        ctrl.ins      = 1'b0;
        ctrl.del      = 1'b0;
        ctrl.position = in_position;
        if (s_fire)
        begin
            case (in_command)
                CMD_CLEAR:
                begin
                    len_next = '0;
                end
                CMD_INSERT:
                begin
                    if (pos_c > len_c)
                        status_now = ST_BAD_POS;
                    else if (len_reg == LEN_W'(CAPACITY))
                        status_now = ST_FULL;
                    else
                    begin
                        ctrl.ins = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (pos_c >= len_c)
                        status_now = ST_BAD_POS;
                    else
                    begin
                        ctrl.del = 1'b1;
                        len_next = len_reg - LEN_W'(1);
                    end
                end
                CMD_READ:
                begin
                    if (pos_c >= len_c)
                        status_now = ST_BAD_POS;
                    else
                        rd_now = VALUE_W'(rd_sel);
                end
                default:
                begin
                    status_now = ST_DONE;
                end
            endcase
        end
    end

    // the row of cells; each end sees a constant neighbour
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        iida_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .load_value (val_fit),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .rd_data    (cell_rd[g])
        );
    end

    // valid drops once the word is taken, unless a new one replaces it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            res_status_reg <= status_now;
            res_rd_reg     <= rd_now;
            res_count_reg  <= COUNT_W'(len_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - STATUS_W - VALUE_W - COUNT_W)'(0),
        res_count_reg,
        res_rd_reg,
        res_status_reg
    };

    // a full status is only ever reported with the array at capacity
    `IIDA_ASSERT_NOW(a_full_at_capacity, out_valid_reg && (res_status_reg == ST_FULL), res_count_reg == COUNT_W'(CAPACITY), "full status with count below capacity")
    // a completed insert grows the count by exactly one
    `IIDA_ASSERT_NEXT(a_insert_grows, ctrl.ins, len_reg == $past(len_reg) + LEN_W'(1), "insert did not advance count")
    // read data appears only on a successful command
    `IIDA_ASSERT_NOW(a_rd_only_done, out_valid_reg && (res_rd_reg != '0), res_status_reg == ST_DONE, "read data on failed command")
    // the count never passes capacity
    `IIDA_ASSERT_NOW(a_len_bound, out_valid_reg, len_reg <= LEN_W'(CAPACITY), "count above capacity")

endmodule
